// File: rtl/tvlp_pkg.sv
// Shared types and constants of the tag/value line parser.
// No dependencies; the parser top level and the testbench import this package.
package tvlp_pkg;

    localparam int LINE_LIMIT = 256;

    // Line byte counter holds 0..LINE_LIMIT.
    localparam int LINE_W = $clog2(LINE_LIMIT + 1);
    // Tag/value counters: at least as wide as the 9-bit length fields, so
    // reported lengths wrap exactly like the field widths.
    localparam int CNT_W = (LINE_W > 9) ? LINE_W : 9;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        CMD_CHAR = 2'd0,
        CMD_EOL  = 2'd1,
        CMD_EOF  = 2'd2,
        CMD_NONE = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        KIND_TAG    = 2'd0,
        KIND_VALUE  = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_NO_TAG        = 3'd1,
        ST_NO_VALUE      = 3'd2,
        ST_COMMENT_COLON = 3'd3,
        ST_NO_COLON      = 3'd4,
        ST_EOF           = 3'd5
    } t_status;

    typedef enum logic [7:0] {
        MODE_LEAD      = 8'b0000_0001,
        MODE_TAG       = 8'b0000_0010,
        MODE_VLEAD     = 8'b0000_0100,
        MODE_VAL       = 8'b0000_1000,
        MODE_COMMENT   = 8'b0001_0000,
        MODE_NO_TAG    = 8'b0010_0000,
        MODE_VAL_DONE  = 8'b0100_0000,
        MODE_BAD_COLON = 8'b1000_0000
    } t_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] position;
        logic [7:0] out_char;
        logic [2:0] status;
        logic [8:0] tag_length;
        logic [8:0] value_length;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

// File: rtl/tvlp_if.sv
// Valid/ready channel interfaces of the tag/value line parser.
// Depends on nothing; the parser top level uses both.
interface tvlp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] char_code;

    modport source (output valid, output command, output char_code, input ready);
    modport sink   (input valid, input command, input char_code, output ready);
endinterface

interface tvlp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] position;
    logic [7:0] out_char;
    logic [2:0] status;
    logic [8:0] tag_length;
    logic [8:0] value_length;

    modport source (output valid, output kind, output position, output out_char,
                    output status, output tag_length, output value_length,
                    input ready);
    modport sink   (input valid, input kind, input position, input out_char,
                    input status, input tag_length, input value_length,
                    output ready);
endinterface

// File: rtl/tag_value_line_parser.sv
// Tag/value line parser: top level with parse state and output buffer.
// Depends on tvlp_pkg and the channel interfaces in tvlp_if.sv.
//
// Usage: feed one byte-stream command per transfer on i_in (command 0 with a
// byte in char_code, 1 for end of line, 2 for end of file). Each transfer
// causes at most one result transfer on o_out: kind 0 for a byte of the text
// before the colon, kind 1 for a value byte, both with their position, and
// kind 2 with the line status and trimmed tag/value lengths.
// Blank and comment lines give nothing at end of line; bytes past LINE_LIMIT
// in one line are dropped.
// Results are registered: each waits in the result register, or behind it in the skid register, before o_out.
// Throughput: one input transfer per cycle while the skid register is empty, as the
// mode and counter update between the parse-state registers and the result register is combinational.
// Stall: a two-entry output buffer (result register plus skid register)
// keeps taking input while one result waits; i_in.ready drops only when both
// entries hold results.
// Reset (i_rst_n low, synchronous): parse state returns to leading
// whitespace with all counters cleared, and both output entries empty.
module tag_value_line_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tvlp_in_if.sink           i_in,
    tvlp_out_if.source        o_out
);
    import tvlp_pkg::*;

    // Parse state
    t_mode             r_mode,          n_mode;
    logic [CNT_W-1:0]  r_tag_count,     n_tag_count;
    logic [CNT_W-1:0]  r_tag_trimmed,   n_tag_trimmed;
    logic [CNT_W-1:0]  r_value_count,   n_value_count;
    logic [CNT_W-1:0]  r_value_trimmed, n_value_trimmed;
    logic [LINE_W-1:0] r_line_count,    n_line_count;
    logic              r_comment_seen,  n_comment_seen;

    // Output buffer
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    t_result  w_res;
    logic     w_has_res;
    logic     w_in_xfer;
    logic     w_out_xfer;
    logic     w_push;
    t_command w_cmd;
    logic [7:0] w_c;

    assign w_cmd      = t_command'(i_in.command);
    assign w_c        = i_in.char_code;
    assign i_in.ready = !r_skid_valid;
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = r_out_valid && o_out.ready;
    assign w_push     = w_in_xfer && w_has_res;

    // Next parse state and the result of the offered item.
    always_comb begin
        n_mode          = r_mode;
        n_tag_count     = r_tag_count;
        n_tag_trimmed   = r_tag_trimmed;
        n_value_count   = r_value_count;
        n_value_trimmed = r_value_trimmed;
        n_line_count    = r_line_count;
        n_comment_seen  = r_comment_seen;
        w_has_res       = 1'b0;
        w_res           = '0;

        case (w_cmd)
            CMD_CHAR: begin
                if (r_line_count < LINE_W'(LINE_LIMIT)) begin
                    n_line_count = r_line_count + LINE_W'(1);
                    case (r_mode)
                        MODE_LEAD: begin
                            if (is_space(w_c)) begin
                                n_mode = MODE_LEAD;
                            end else if (w_c == CH_HASH) begin
                                n_mode = MODE_COMMENT;
                            end else if (w_c == CH_COLON) begin
                                n_mode = MODE_NO_TAG;
                            end else begin
                                n_mode = MODE_TAG;
                                w_has_res = 1'b1;
                            end
                        end
                        MODE_TAG: begin
                            if (w_c == CH_COLON) begin
                                n_mode = r_comment_seen ? MODE_BAD_COLON : MODE_VLEAD;
                            end else begin
                                if (w_c == CH_HASH) begin
                                    n_comment_seen = 1'b1;
                                end
                                w_has_res = 1'b1;
                            end
                        end
                        MODE_VLEAD: begin
                            if (is_space(w_c)) begin
                                n_mode = MODE_VLEAD;
                            end else if (w_c == CH_HASH) begin
                                n_mode = MODE_VAL_DONE;
                            end else begin
                                n_mode = MODE_VAL;
                                w_has_res = 1'b1;
                            end
                        end
                        MODE_VAL: begin
                            if (w_c == CH_HASH) begin
                                n_mode = MODE_VAL_DONE;
                            end else begin
                                w_has_res = 1'b1;
                            end
                        end
                        default: begin
                            n_mode = r_mode;
                        end
                    endcase

                    // Emit a tag or value byte and advance its counters.
                    if (w_has_res) begin
                        w_res.out_char = w_c;
                        if (r_mode == MODE_LEAD || r_mode == MODE_TAG) begin
                            w_res.kind     = KIND_TAG;
                            w_res.position = r_tag_count[7:0];
                            n_tag_count    = r_tag_count + CNT_W'(1);
                            if (!is_space(w_c)) begin
                                n_tag_trimmed = r_tag_count + CNT_W'(1);
                            end
                        end else begin
                            w_res.kind      = KIND_VALUE;
                            w_res.position  = r_value_count[7:0];
                            n_value_count   = r_value_count + CNT_W'(1);
                            if (!is_space(w_c)) begin
                                n_value_trimmed = r_value_count + CNT_W'(1);
                            end
                        end
                    end
                end
            end
            CMD_EOL: begin
                w_res.kind = KIND_STATUS;
                case (r_mode)
                    MODE_TAG: begin
                        w_has_res        = 1'b1;
                        w_res.status     = ST_NO_COLON;
                        w_res.tag_length = r_tag_trimmed[8:0];
                    end
                    MODE_VLEAD, MODE_VAL, MODE_VAL_DONE: begin
                        w_has_res        = 1'b1;
                        w_res.tag_length = r_tag_trimmed[8:0];
                        if (r_value_trimmed == '0) begin
                            w_res.status = ST_NO_VALUE;
                        end else begin
                            w_res.status       = ST_OK;
                            w_res.value_length = r_value_trimmed[8:0];
                        end
                    end
                    MODE_NO_TAG: begin
                        w_has_res    = 1'b1;
                        w_res.status = ST_NO_TAG;
                    end
                    MODE_BAD_COLON: begin
                        w_has_res        = 1'b1;
                        w_res.status     = ST_COMMENT_COLON;
                        w_res.tag_length = r_tag_trimmed[8:0];
                    end
                    default: begin
                        w_has_res = 1'b0;
                    end
                endcase
                n_mode          = MODE_LEAD;
                n_tag_count     = '0;
                n_tag_trimmed   = '0;
                n_value_count   = '0;
                n_value_trimmed = '0;
                n_line_count    = '0;
                n_comment_seen  = 1'b0;
            end
            CMD_EOF: begin
                w_has_res       = 1'b1;
                w_res.kind      = KIND_STATUS;
                w_res.status    = ST_EOF;
                n_mode          = MODE_LEAD;
                n_tag_count     = '0;
                n_tag_trimmed   = '0;
                n_value_count   = '0;
                n_value_trimmed = '0;
                n_line_count    = '0;
                n_comment_seen  = 1'b0;
            end
            default: begin
                // Unknown command: drop, no state change.
                w_has_res = 1'b0;
            end
        endcase
    end

    // Parse state: advance on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_LEAD;
            r_tag_count     <= '0;
            r_tag_trimmed   <= '0;
            r_value_count   <= '0;
            r_value_trimmed <= '0;
            r_line_count    <= '0;
            r_comment_seen  <= 1'b0;
        end else if (w_in_xfer) begin
            r_mode          <= n_mode;
            r_tag_count     <= n_tag_count;
            r_tag_trimmed   <= n_tag_trimmed;
            r_value_count   <= n_value_count;
            r_value_trimmed <= n_value_trimmed;
            r_line_count    <= n_line_count;
            r_comment_seen  <= n_comment_seen;
        end
    end

    // Output buffer control. A push never meets a full skid, since input
    // ready is held low while the skid holds a result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_out_xfer) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_push;
                end
            end else if (!r_out_valid) begin
                r_out_valid <= w_push;
            end else if (w_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Output buffer payload.
    always_ff @(posedge i_clk) begin
        if (w_out_xfer) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_push) begin
                r_out <= w_res;
            end
        end else if (!r_out_valid) begin
            if (w_push) begin
                r_out <= w_res;
            end
        end else if (w_push) begin
            r_skid <= w_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out.kind;
    assign o_out.position     = r_out.position;
    assign o_out.out_char     = r_out.out_char;
    assign o_out.status       = r_out.status;
    assign o_out.tag_length   = r_out.tag_length;
    assign o_out.value_length = r_out.value_length;

    // Skid entry only fills behind a held result register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the result register is empty");

    // A result waiting in both entries must block new input.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_skid_valid && !o_out.ready) |=> r_skid_valid)
        else $error("skid result lost while the receiver stalls");

    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_count <= LINE_W'(LINE_LIMIT))
        else $error("line byte count beyond the line limit");

    a_trim_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tag_trimmed <= r_tag_count) && (r_value_trimmed <= r_value_count))
        else $error("trimmed length exceeds the byte count");

    // Counters of a finished line are cleared by the end-of-line or end-of-file transfer itself.
    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (w_cmd == CMD_EOL || w_cmd == CMD_EOF))
            |=> (r_mode == MODE_LEAD) && (r_line_count == '0))
        else $error("line state not cleared at end of line or file");

endmodule

// File: verif/tb_tag_value_line_parser.sv
// Self-checking testbench for the tag/value line parser: drives byte-stream
// commands into i_in, predicts every result and checks each transfer on o_out.
// Depends on tvlp_pkg, the channel interfaces in tvlp_if.sv and the parser RTL.
module tb_tag_value_line_parser;
    import tvlp_pkg::*;

    function automatic bit is_ws(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    // Tracks the parse state of the current line and holds the results that
    // the parser still owes, oldest first.
    class line_parse_tracker;
        t_result     awaited_results[$];
        t_mode       mode;
        logic [8:0]  tag_count;
        logic [8:0]  tag_trimmed;
        logic [8:0]  value_count;
        logic [8:0]  value_trimmed;
        int          line_bytes;
        bit          hash_in_tag;
        int unsigned mismatches;
        int unsigned results_checked;
        int unsigned statuses_checked;

        function new();
            clear_line();
            mismatches       = 0;
            results_checked  = 0;
            statuses_checked = 0;
        endfunction

        function void clear_line();
            mode          = MODE_LEAD;
            tag_count     = '0;
            tag_trimmed   = '0;
            value_count   = '0;
            value_trimmed = '0;
            line_bytes    = 0;
            hash_in_tag   = 1'b0;
        endfunction

        // Emit one tag or value byte and advance its counters.
        function t_result text_byte(input bit in_value, input logic [7:0] ch);
            t_result r;
            r = '0;
            r.out_char = ch;
            if (in_value) begin
                r.kind     = KIND_VALUE;
                r.position = value_count[7:0];
                value_count++;
                if (!is_ws(ch))
                    value_trimmed = value_count;
            end else begin
                r.kind     = KIND_TAG;
                r.position = tag_count[7:0];
                tag_count++;
                if (!is_ws(ch))
                    tag_trimmed = tag_count;
            end
            return r;
        endfunction

        function void note_transfer(input logic [1:0] cmd, input logic [7:0] ch);
            t_result r;
            bit      produced;
            r        = '0;
            produced = 1'b0;
            if (cmd == CMD_CHAR) begin
                // Bytes past the line limit are dropped without touching state.
                if (line_bytes < LINE_LIMIT) begin
                    line_bytes++;
                    case (mode)
                        MODE_LEAD: begin
                            if (ch == CH_HASH)
                                mode = MODE_COMMENT;
                            else if (ch == CH_COLON)
                                mode = MODE_NO_TAG;
                            else if (!is_ws(ch)) begin
                                mode     = MODE_TAG;
                                r        = text_byte(1'b0, ch);
                                produced = 1'b1;
                            end
                        end
                        MODE_TAG: begin
                            if (ch == CH_COLON)
                                mode = hash_in_tag ? MODE_BAD_COLON : MODE_VLEAD;
                            else begin
                                if (ch == CH_HASH)
                                    hash_in_tag = 1'b1;
                                r        = text_byte(1'b0, ch);
                                produced = 1'b1;
                            end
                        end
                        MODE_VLEAD, MODE_VAL: begin
                            // A hash ends the value; leading whitespace is skipped.
                            if (ch == CH_HASH)
                                mode = MODE_VAL_DONE;
                            else if (mode == MODE_VAL || !is_ws(ch)) begin
                                mode     = MODE_VAL;
                                r        = text_byte(1'b1, ch);
                                produced = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end else if (cmd == CMD_EOL) begin
                produced = 1'b1;
                r.kind   = KIND_STATUS;
                case (mode)
                    MODE_TAG: begin
                        r.status     = ST_NO_COLON;
                        r.tag_length = tag_trimmed;
                    end
                    MODE_VLEAD, MODE_VAL, MODE_VAL_DONE: begin
                        r.tag_length = tag_trimmed;
                        if (value_trimmed == 0)
                            r.status = ST_NO_VALUE;
                        else begin
                            r.status       = ST_OK;
                            r.value_length = value_trimmed;
                        end
                    end
                    MODE_NO_TAG: r.status = ST_NO_TAG;
                    MODE_BAD_COLON: begin
                        r.status     = ST_COMMENT_COLON;
                        r.tag_length = tag_trimmed;
                    end
                    // Blank and comment lines end silently.
                    default: produced = 1'b0;
                endcase
                clear_line();
            end else if (cmd == CMD_EOF) begin
                clear_line();
                produced = 1'b1;
                r.kind   = KIND_STATUS;
                r.status = ST_EOF;
            end
            if (produced)
                awaited_results.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [8:0] want,
                                    input logic [8:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                $error("kind: expected no result, got %0d", got.kind);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("position", want.position, got.position);
            compare_field("out_char", want.out_char, got.out_char);
            compare_field("status", want.status, got.status);
            compare_field("tag_length", want.tag_length, got.tag_length);
            compare_field("value_length", want.value_length, got.value_length);
            results_checked++;
            if (want.kind == KIND_STATUS)
                statuses_checked++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    int   items_sent;

    line_parse_tracker tracker;

    tvlp_in_if  in_bus ();
    tvlp_out_if out_bus ();

    tag_value_line_parser DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: stall at random per cycle, at the rate of the current phase.
    initial begin
        out_bus.ready = 1'b1;
        forever begin
            @(negedge clk);
            out_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Note accepted commands first, then check accepted results.
    always @(posedge clk) begin : monitor
        t_result got;
        if (rst_n) begin
            if (in_bus.valid && in_bus.ready)
                tracker.note_transfer(in_bus.command, in_bus.char_code);
            if (out_bus.valid && out_bus.ready) begin
                got = {out_bus.kind, out_bus.position, out_bus.out_char,
                       out_bus.status, out_bus.tag_length, out_bus.value_length};
                tracker.check_result(got);
            end
        end
    end

    // Hold the command until the parser takes it; idle at random before it.
    task automatic send_item(input t_command cmd, input logic [7:0] ch);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.command   <= cmd;
        in_bus.char_code <= ch;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        if (cmd != CMD_NONE)
            items_sent++;
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_item(CMD_CHAR, ch);
    endtask

    task automatic send_line(input string s);
        foreach (s[i])
            send_char(s[i]);
        send_item(CMD_EOL, 8'h00);
    endtask

    function automatic logic [7:0] rand_ws();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // Any byte that is neither whitespace, colon nor hash.
    function automatic logic [7:0] rand_text_char();
        logic [7:0] c;
        do
            c = rand_byte();
        while (is_ws(c) || c == CH_COLON || c == CH_HASH);
        return c;
    endfunction

    // Value bytes may carry whitespace and colons but no hash.
    function automatic logic [7:0] rand_value_char();
        logic [7:0] c;
        do
            c = rand_byte();
        while (c == CH_HASH);
        return c;
    endfunction

    // Lines that reach or run past the line limit, one shape per phase.
    task automatic send_long_line(input int shape);
        case (shape)
            0: begin
                repeat ($urandom_range(256, 300))
                    send_char(rand_text_char());
            end
            1: begin
                send_char(rand_text_char());
                send_char(CH_COLON);
                repeat ($urandom_range(256, 300))
                    send_char(rand_text_char());
            end
            default: begin
                repeat (100)
                    send_char(rand_ws());
                repeat (120)
                    send_char(rand_text_char());
                send_char(CH_COLON);
                repeat (100)
                    send_char(rand_value_char());
            end
        endcase
        send_item(CMD_EOL, 8'h00);
    endtask

    task automatic send_random_line();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 65) begin
            // Well-formed line with random content.
            repeat ($urandom_range(3))
                send_char(rand_ws());
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_char((i > 0 && $urandom_range(9) == 0) ? CH_SPACE : rand_text_char());
            repeat ($urandom_range(2))
                send_char(rand_ws());
            send_char(CH_COLON);
            repeat ($urandom_range(3))
                send_char(rand_ws());
            repeat ($urandom_range(10))
                send_char(rand_value_char());
            if ($urandom_range(7) == 0) begin
                send_char(CH_HASH);
                repeat ($urandom_range(4))
                    send_char(rand_byte());
            end
            repeat ($urandom_range(2))
                send_char(rand_ws());
            send_item(($urandom_range(19) == 0) ? CMD_EOF : CMD_EOL, 8'h00);
        end else if (pick < 75) begin
            // Blank or comment line.
            repeat ($urandom_range(3))
                send_char(rand_ws());
            if ($urandom_range(1)) begin
                send_char(CH_HASH);
                repeat ($urandom_range(8))
                    send_char(rand_byte());
            end
            send_item(CMD_EOL, 8'h00);
        end else if (pick < 85) begin
            // Broken lines: colon first, hash in the tag, or no colon at all.
            repeat ($urandom_range(2))
                send_char(rand_ws());
            case ($urandom_range(2))
                0: send_char(CH_COLON);
                1: begin
                    repeat ($urandom_range(1, 3))
                        send_char(rand_text_char());
                    send_char(CH_HASH);
                    repeat ($urandom_range(3))
                        send_char(rand_text_char());
                    if ($urandom_range(3) != 0)
                        send_char(CH_COLON);
                end
                default: begin
                    repeat ($urandom_range(1, 6))
                        send_char($urandom_range(1) ? rand_text_char() : rand_ws());
                end
            endcase
            repeat ($urandom_range(5))
                send_char(rand_byte());
            send_item(CMD_EOL, 8'h00);
        end else begin
            // Noise: any command with any byte.
            repeat ($urandom_range(1, 12))
                send_item(t_command'($urandom_range(3)), rand_byte());
        end
    endtask

    initial begin
        tracker           = new();
        items_sent        = 0;
        sender_idle_pct   = 15;
        receiver_idle_pct = 66;
        rst_n             = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.command    = CMD_CHAR;
        in_bus.char_code  = 8'h00;
        repeat (3)
            @(negedge clk);
        rst_n <= 1'b1;

        // Directed: comment line, blank line, colon first, hash before the
        // colon, empty value, hash in the value, no colon, partial line at
        // end of file, unknown command, byte extremes.
        send_line(" #x");
        send_item(CMD_EOL, 8'h00);
        send_line(":z");
        send_char(8'hFF);
        send_line("#:");
        send_line("k: ");
        send_char("q");
        send_char(CH_COLON);
        send_char(8'h00);
        send_line("#w");
        send_line("b ");
        send_char("x");
        send_item(CMD_EOF, 8'h00);
        send_item(CMD_NONE, 8'hFF);

        // Random: three idle profiles, each opening with one overlong line.
        for (int p = 0; p < 3; p++) begin
            sender_idle_pct   = (p == 0) ? 15 : (p == 1) ? 66 : 0;
            receiver_idle_pct = (p == 0) ? 66 : (p == 1) ? 15 : 0;
            send_long_line(p);
            while (items_sent < (p + 1) * 650)
                send_random_line();
        end

        @(negedge clk);
        in_bus.valid <= 1'b0;

        // Drain: wait until every owed result has been checked.
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);

        $display("Sent %0d commands; checked %0d results, %0d of them line statuses.",
                 items_sent, tracker.results_checked, tracker.statuses_checked);
        if (tracker.mismatches == 0 && tracker.awaited_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results still owed.", tracker.awaited_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
